// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers; they expect clk and rst_n in the using scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed: property violated");
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed: forbidden condition seen");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== design/fsk_pkg.sv =====
// ----------------------------------------------------------------------------
// FSK demodulator package
// Types, constants, register map, sine table and arithmetic helpers.
// ----------------------------------------------------------------------------
package fsk_pkg;

  localparam int WIN_DEPTH   = 256;
  localparam int WIN_AW      = $clog2(WIN_DEPTH);
  localparam int WIN_LEN_W   = $clog2(WIN_DEPTH + 1);
  localparam int WSUM_W      = 24 + WIN_AW + 1;
  localparam int WABS_W      = 24 + WIN_AW;

  localparam int SINE_DEPTH  = 1024;
  localparam int SINE_AW     = $clog2(SINE_DEPTH);
  localparam logic [SINE_AW-1:0] SINE_QTR = SINE_AW'(SINE_DEPTH / 4);

  localparam longint unsigned SIN_C1 = 64'd1686629713;
  localparam longint unsigned SIN_C2 = 64'd688904916;
  localparam longint unsigned SIN_C3 = 64'd76016958;

  localparam int CFG_AW = 5;

  localparam logic [19:0] CLOCK_MAX = 20'hFFFFF;
  localparam logic [9:0]  RUN_MAX   = 10'd1023;

  // register map
  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_PHASE_STEP    = 3'd0;
  localparam reg_idx_t REG_FILTER_GAIN   = 3'd1;
  localparam reg_idx_t REG_BIT_PERIOD    = 3'd2;
  localparam reg_idx_t REG_INVERT_SENSE  = 3'd3;
  localparam reg_idx_t REG_CLOCK_MODE    = 3'd4;
  localparam reg_idx_t REG_RUN_THRESHOLD = 3'd5;
  localparam reg_idx_t REG_WINDOW_LENGTH = 3'd6;

  localparam logic [15:0] RST_FILTER_GAIN   = 16'd6554;
  localparam logic [19:0] RST_BIT_PERIOD    = 20'd10240;
  localparam logic [1:0]  RST_CLOCK_MODE    = 2'd1;
  localparam logic [8:0]  RST_RUN_THRESHOLD = 9'd4;
  localparam logic [8:0]  RST_WINDOW_LENGTH = 9'd8;
  localparam logic [WIN_LEN_W-1:0] RST_WIN_LEN = WIN_LEN_W'(8);

  localparam logic [1:0] MODE_SIGN   = 2'd0;
  localparam logic [1:0] MODE_RUN    = 2'd1;
  localparam logic [1:0] MODE_WINDOW = 2'd2;

  // datapath operations
  typedef logic [3:0] op_t;
  localparam op_t OP_MIX_Q    = 4'd0;
  localparam op_t OP_MIX_I    = 4'd1;
  localparam op_t OP_LP_FIRST = 4'd2;
  localparam op_t OP_LP_LAST  = 4'd9;
  localparam op_t OP_DISC_A   = 4'd10;
  localparam op_t OP_DISC_B   = 4'd11;
  localparam op_t OP_SMOOTH   = 4'd12;
  localparam op_t OP_LAST     = OP_SMOOTH;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_ISSUE,
    ST_COMMIT,
    ST_WIN,
    ST_ADJUST,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [31:0]          phase_step;
    logic [15:0]          filter_gain;
    logic [19:0]          bit_period;
    logic                 invert_sense;
    logic [1:0]           clock_mode;
    logic [8:0]           run_threshold;
    logic [WIN_LEN_W-1:0] win_len;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic issue;
    logic commit;
    logic win;
    logic adjust;
    logic finish;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic out_busy;
  } sts_t;

  typedef logic signed [15:0] sine_lut_t [SINE_DEPTH];

  function automatic logic signed [15:0] sine_entry(input int unsigned n);
    longint unsigned pq;
    longint unsigned r;
    longint unsigned z;
    longint unsigned z2;
    longint unsigned t;
    longint unsigned q;
    logic            neg;
    pq  = (64'(n) << (32 - SINE_AW)) & 64'hFFFF_FFFF;
    neg = pq[31];
    r   = pq & 64'h7FFF_FFFF;
    if (r > 64'h4000_0000) r = 64'h8000_0000 - r;
    z  = r;
    z2 = (z * z) >> 30;
    t  = SIN_C2 - ((SIN_C3 * z2) >> 30);
    t  = SIN_C1 - ((z2 * t) >> 30);
    q  = (((z * t) >> 30) + 64'd16384) >> 15;
    if (q > 64'd32767) q = 64'd32767;
    return neg ? -$signed(q[15:0]) : $signed(q[15:0]);
  endfunction

  function automatic sine_lut_t build_sine_lut();
    sine_lut_t lut;
    for (int k = 0; k < SINE_DEPTH; k++) lut[k] = sine_entry(k);
    return lut;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine_lut();

  function automatic logic signed [23:0] sat24(input logic signed [49:0] v);
    if (v > 50'sd8388607) return 24'sh7FFFFF;
    else if (v < -50'sd8388608) return 24'sh800000;
    else return v[23:0];
  endfunction

  function automatic logic [23:0] abs24(input logic signed [23:0] v);
    return v[23] ? 24'(-v) : 24'(v);
  endfunction

endpackage

// ===== design/fsk_regs.sv =====
// ----------------------------------------------------------------------------
// FSK register block
// APB-style configuration registers, read back and window length clamp.
// ----------------------------------------------------------------------------
module fsk_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [fsk_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready,
  output fsk_pkg::cfg_t             cfg,
  output logic                      win_clear,
  output logic [fsk_pkg::WIN_LEN_W-1:0] win_len_wr
);

  logic [31:0] phase_step_r;
  logic [15:0] filter_gain_r;
  logic [19:0] bit_period_r;
  logic        invert_sense_r;
  logic [1:0]  clock_mode_r;
  logic [8:0]  run_threshold_r;
  logic [8:0]  window_length_r;
  logic        wr;
  fsk_pkg::reg_idx_t idx;

  assign cfg_pready = 1'b1;
  assign wr  = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx = cfg_paddr[fsk_pkg::CFG_AW-1:2];
  assign win_clear = wr && (idx == fsk_pkg::REG_WINDOW_LENGTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r    <= '0;
      filter_gain_r   <= fsk_pkg::RST_FILTER_GAIN;
      bit_period_r    <= fsk_pkg::RST_BIT_PERIOD;
      invert_sense_r  <= 1'b0;
      clock_mode_r    <= fsk_pkg::RST_CLOCK_MODE;
      run_threshold_r <= fsk_pkg::RST_RUN_THRESHOLD;
      window_length_r <= fsk_pkg::RST_WINDOW_LENGTH;
    end else if (wr) begin
      unique case (idx)
        fsk_pkg::REG_PHASE_STEP:    phase_step_r    <= cfg_pwdata;
        fsk_pkg::REG_FILTER_GAIN:   filter_gain_r   <= cfg_pwdata[15:0];
        fsk_pkg::REG_BIT_PERIOD:    bit_period_r    <= cfg_pwdata[19:0];
        fsk_pkg::REG_INVERT_SENSE:  invert_sense_r  <= cfg_pwdata[0];
        fsk_pkg::REG_CLOCK_MODE:    clock_mode_r    <= cfg_pwdata[1:0];
        fsk_pkg::REG_RUN_THRESHOLD: run_threshold_r <= cfg_pwdata[8:0];
        fsk_pkg::REG_WINDOW_LENGTH: window_length_r <= cfg_pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      fsk_pkg::REG_PHASE_STEP:    cfg_prdata = phase_step_r;
      fsk_pkg::REG_FILTER_GAIN:   cfg_prdata = 32'(filter_gain_r);
      fsk_pkg::REG_BIT_PERIOD:    cfg_prdata = 32'(bit_period_r);
      fsk_pkg::REG_INVERT_SENSE:  cfg_prdata = 32'(invert_sense_r);
      fsk_pkg::REG_CLOCK_MODE:    cfg_prdata = 32'(clock_mode_r);
      fsk_pkg::REG_RUN_THRESHOLD: cfg_prdata = 32'(run_threshold_r);
      fsk_pkg::REG_WINDOW_LENGTH: cfg_prdata = 32'(window_length_r);
      default:                    cfg_prdata = '0;
    endcase
  end

  always_comb begin
    cfg.phase_step    = phase_step_r;
    cfg.filter_gain   = filter_gain_r;
    cfg.bit_period    = bit_period_r;
    cfg.invert_sense  = invert_sense_r;
    cfg.clock_mode    = clock_mode_r;
    cfg.run_threshold = run_threshold_r;
    if (window_length_r == '0) cfg.win_len = fsk_pkg::WIN_LEN_W'(1);
    else if (32'(window_length_r) > fsk_pkg::WIN_DEPTH)
      cfg.win_len = fsk_pkg::WIN_LEN_W'(fsk_pkg::WIN_DEPTH);
    else cfg.win_len = fsk_pkg::WIN_LEN_W'(window_length_r);
  end

  // clamped length being written, for the rearm count on a ring clear
  always_comb begin
    if (cfg_pwdata[8:0] == '0) win_len_wr = fsk_pkg::WIN_LEN_W'(1);
    else if (32'(cfg_pwdata[8:0]) > fsk_pkg::WIN_DEPTH)
      win_len_wr = fsk_pkg::WIN_LEN_W'(fsk_pkg::WIN_DEPTH);
    else win_len_wr = fsk_pkg::WIN_LEN_W'(cfg_pwdata[8:0]);
  end

endmodule

// ===== design/fsk_ctrl.sv =====
// ----------------------------------------------------------------------------
// FSK controller
// Sequences one sample through the shared multiplier and clock recovery.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fsk_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  fsk_pkg::sts_t sts,
  output fsk_pkg::cmd_t cmd
);

  fsk_pkg::state_t state_r;
  fsk_pkg::state_t state_nxt;
  fsk_pkg::op_t    op_r;
  fsk_pkg::op_t    op_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsk_pkg::ST_IDLE;
      op_r    <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    unique case (state_r)
      fsk_pkg::ST_IDLE:   if (in_valid) state_nxt = fsk_pkg::ST_PREP;
      fsk_pkg::ST_PREP: begin
        state_nxt = fsk_pkg::ST_ISSUE;
        op_nxt    = fsk_pkg::OP_MIX_Q;
      end
      fsk_pkg::ST_ISSUE:  state_nxt = fsk_pkg::ST_COMMIT;
      fsk_pkg::ST_COMMIT: begin
        if (op_r == fsk_pkg::OP_LAST) begin
          state_nxt = fsk_pkg::ST_WIN;
        end else begin
          state_nxt = fsk_pkg::ST_ISSUE;
          op_nxt    = op_r + 4'd1;
        end
      end
      fsk_pkg::ST_WIN:    state_nxt = fsk_pkg::ST_ADJUST;
      fsk_pkg::ST_ADJUST: state_nxt = fsk_pkg::ST_FINISH;
      fsk_pkg::ST_FINISH: if (!(sts.emit && sts.out_busy)) state_nxt = fsk_pkg::ST_IDLE;
      default:            state_nxt = fsk_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = (state_r != fsk_pkg::ST_IDLE);
    cmd        = '0;
    cmd.op     = op_r;
    cmd.load   = (state_r == fsk_pkg::ST_IDLE) && in_valid;
    cmd.prep   = (state_r == fsk_pkg::ST_PREP);
    cmd.issue  = (state_r == fsk_pkg::ST_ISSUE);
    cmd.commit = (state_r == fsk_pkg::ST_COMMIT);
    cmd.win    = (state_r == fsk_pkg::ST_WIN);
    cmd.adjust = (state_r == fsk_pkg::ST_ADJUST);
    cmd.finish = (state_r == fsk_pkg::ST_FINISH) && !(sts.emit && sts.out_busy);
  end

  `ASSERT_CLK(a_load_to_prep, cmd.load |=> state_r == fsk_pkg::ST_PREP)
  `ASSERT_CLK(a_last_op_to_win, (cmd.commit && op_r == fsk_pkg::OP_LAST) |=> cmd.win)
  `ASSERT_NEVER(a_op_range, (cmd.issue || cmd.commit) && op_r > fsk_pkg::OP_LAST)

endmodule

// ===== design/fsk_datapath.sv =====
// ----------------------------------------------------------------------------
// FSK datapath
// NCO, shared multiplier, lowpass rails, discriminator, window ring, bit timer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fsk_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  fsk_pkg::cmd_t       cmd,
  input  fsk_pkg::cfg_t       cfg,
  input  logic                win_clear,
  input  logic [fsk_pkg::WIN_LEN_W-1:0] win_len_wr,
  input  logic signed [15:0]  in_sample,
  input  logic                out_stall,
  output fsk_pkg::sts_t       sts,
  output logic                out_valid,
  output logic                out_data_bit
);

  localparam int WS = fsk_pkg::WSUM_W;
  localparam int WA = fsk_pkg::WABS_W;
  localparam int LW = fsk_pkg::WIN_LEN_W;

  logic signed [15:0] sample_r;
  logic [31:0]        phase_r;
  logic signed [15:0] sine_r;
  logic signed [49:0] prod_r;
  logic signed [23:0] x_i_r;
  logic signed [23:0] x_q_r;
  logic signed [23:0] lp_i_r [4];
  logic signed [23:0] lp_q_r [4];
  logic signed [23:0] prev_i_r;
  logic signed [23:0] prev_q_r;
  logic signed [47:0] tmp_r;
  logic signed [23:0] disc_r;
  logic signed [23:0] sd_r;
  logic signed [39:0] bit_sum_r;
  logic signed [39:0] prev_sum_r;
  logic [19:0]        bc_r;
  logic [9:0]         run_r;
  logic               await_neg_r;
  logic               last_sign_r;
  logic [fsk_pkg::WIN_AW-1:0] ptr_r;
  logic               wrap_r;
  logic signed [WS-1:0] wsum_r;
  logic [WA-1:0]      wabs_r;
  logic [LW-1:0]      rearm_r;
  logic signed [23:0] mem [fsk_pkg::WIN_DEPTH];
  logic signed [23:0] rd_r;
  logic               out_valid_r;
  logic               out_bit_r;

  logic [fsk_pkg::SINE_AW-1:0] sin_idx;
  logic [3:0]         lp_off;
  logic [1:0]         stage;
  logic               rail;
  logic signed [23:0] lp_sel;
  logic signed [23:0] x_sel;
  logic signed [24:0] gain_ext;
  logic signed [24:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [23:0] lp_val;
  logic signed [49:0] disc_d;
  logic signed [40:0] sum41;
  logic signed [39:0] sum_sat;
  logic signed [23:0] old_val;
  logic [LW:0]        ptr_inc;
  logic [18:0]        half;
  logic               hit;
  logic [9:0]         run_inc;
  logic [WS-1:0]      wmag;
  logic [WS+2:0]      five_mag;
  logic               pull_en;
  logic [21:0]        pull_tgt;
  logic [21:0]        pull_sum;
  logic [19:0]        pulled;
  logic               sum_clr;
  logic               last_nxt;
  logic [9:0]         run_nxt;
  logic               await_nxt;
  logic [LW-1:0]      rearm_nxt;
  logic [20:0]        bc_add;
  logic [19:0]        bc_inc;
  logic               emit;
  logic               bit_val;

  assign sin_idx  = phase_r[31 -: fsk_pkg::SINE_AW];
  assign lp_off   = cmd.op - fsk_pkg::OP_LP_FIRST;
  assign stage    = lp_off[2:1];
  assign rail     = lp_off[0];
  assign lp_sel   = rail ? lp_q_r[stage] : lp_i_r[stage];
  assign x_sel    = rail ? x_q_r : x_i_r;
  assign gain_ext = $signed(25'(cfg.filter_gain));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op) inside
      fsk_pkg::OP_MIX_Q, fsk_pkg::OP_MIX_I: begin
        mul_a = 25'(sample_r);
        mul_b = 25'(sine_r);
      end
      [fsk_pkg::OP_LP_FIRST:fsk_pkg::OP_LP_LAST]: begin
        mul_a = gain_ext;
        mul_b = 25'(x_sel) - 25'(lp_sel);
      end
      fsk_pkg::OP_DISC_A: begin
        mul_a = 25'(lp_i_r[3]);
        mul_b = 25'(prev_q_r);
      end
      fsk_pkg::OP_DISC_B: begin
        mul_a = 25'(lp_q_r[3]);
        mul_b = 25'(prev_i_r);
      end
      fsk_pkg::OP_SMOOTH: begin
        mul_a = gain_ext;
        mul_b = 25'(disc_r) - 25'(sd_r);
      end
      default: ;
    endcase
  end

  assign lp_val = fsk_pkg::sat24(50'(lp_sel) + (prod_r >>> 16));
  assign disc_d = 50'(tmp_r) - prod_r;

  // window ring and bit sum
  assign sum41   = 41'(bit_sum_r) + 41'(sd_r);
  assign sum_sat = (sum41[40] != sum41[39]) ?
                   (sum41[40] ? 40'sh80_0000_0000 : 40'sh7F_FFFF_FFFF) : sum41[39:0];
  assign old_val = wrap_r ? rd_r : 24'sd0;
  assign ptr_inc = (LW + 1)'(ptr_r) + (LW + 1)'(1);

  // clock recovery
  assign half     = cfg.bit_period[19:1];
  assign hit      = await_neg_r ? sd_r[23] : (!sd_r[23] && (sd_r != 24'sd0));
  assign run_inc  = (run_r == fsk_pkg::RUN_MAX) ? run_r : run_r + 10'd1;
  assign wmag     = wsum_r[WS-1] ? WS'(-wsum_r) : WS'(wsum_r);
  assign five_mag = ((WS + 3)'(wmag) << 2) + (WS + 3)'(wmag);

  always_comb begin
    pull_en   = 1'b0;
    pull_tgt  = '0;
    sum_clr   = 1'b0;
    last_nxt  = last_sign_r;
    run_nxt   = run_r;
    await_nxt = await_neg_r;
    rearm_nxt = rearm_r;
    case (cfg.clock_mode)
      fsk_pkg::MODE_SIGN: begin
        if (!sd_r[23] != last_sign_r) begin
          pull_en  = 1'b1;
          pull_tgt = 22'(half);
          last_nxt = !sd_r[23];
          sum_clr  = 1'b1;
        end
      end
      fsk_pkg::MODE_RUN: begin
        if (hit) begin
          if (run_inc > 10'(cfg.run_threshold)) begin
            pull_en   = 1'b1;
            pull_tgt  = 22'(half) + (22'(cfg.run_threshold) << 8);
            run_nxt   = '0;
            sum_clr   = 1'b1;
            await_nxt = !await_neg_r;
          end else begin
            run_nxt = run_inc;
          end
        end else begin
          run_nxt = '0;
        end
      end
      fsk_pkg::MODE_WINDOW: begin
        if ((rearm_r == '0) && (wabs_r != '0) && (five_mag <= (WS + 3)'(wabs_r))) begin
          pull_en   = 1'b1;
          pull_tgt  = 22'(half) + (22'(cfg.win_len) << 7);
          sum_clr   = 1'b1;
          rearm_nxt = cfg.win_len;
        end
      end
      default: ;
    endcase
  end

  assign pull_sum = 22'(bc_r) + pull_tgt;
  assign pulled   = (pull_sum[21:1] > 21'(fsk_pkg::CLOCK_MAX)) ?
                    fsk_pkg::CLOCK_MAX : pull_sum[20:1];

  // bit timer
  assign bc_add  = 21'(bc_r) + 21'd256;
  assign bc_inc  = bc_add[20] ? fsk_pkg::CLOCK_MAX : bc_add[19:0];
  assign emit    = (bc_inc >= cfg.bit_period);
  assign bit_val = cfg.invert_sense ? (bit_sum_r < prev_sum_r) : (bit_sum_r > prev_sum_r);

  assign sts.emit     = emit;
  assign sts.out_busy = out_valid_r && out_stall;
  assign out_valid    = out_valid_r;
  assign out_data_bit = out_bit_r;

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) sample_r <= in_sample;
    if (cmd.prep) sine_r <= fsk_pkg::SINE_LUT[sin_idx];
    else if (cmd.issue && (cmd.op == fsk_pkg::OP_MIX_Q))
      sine_r <= fsk_pkg::SINE_LUT[sin_idx + fsk_pkg::SINE_QTR];
    if (cmd.issue) prod_r <= mul_a * mul_b;
    if (cmd.commit) begin
      unique case (cmd.op) inside
        fsk_pkg::OP_MIX_Q: x_q_r <= fsk_pkg::sat24(prod_r >>> 8);
        fsk_pkg::OP_MIX_I: x_i_r <= fsk_pkg::sat24(prod_r >>> 8);
        [fsk_pkg::OP_LP_FIRST:fsk_pkg::OP_LP_LAST]: begin
          if (rail) x_q_r <= lp_val;
          else x_i_r <= lp_val;
        end
        fsk_pkg::OP_DISC_A: tmp_r <= prod_r[47:0];
        fsk_pkg::OP_DISC_B: disc_r <= fsk_pkg::sat24(disc_d >>> 22);
        default: ;
      endcase
    end
    if (cmd.finish && emit) out_bit_r <= bit_val;
  end

  // ring memory
  always_ff @(posedge clk) begin
    if (cmd.win && (cfg.clock_mode == fsk_pkg::MODE_WINDOW)) mem[ptr_r] <= sd_r;
    rd_r <= mem[ptr_r];
  end

  // control and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      lp_i_r      <= '{default: '0};
      lp_q_r      <= '{default: '0};
      prev_i_r    <= '0;
      prev_q_r    <= '0;
      sd_r        <= '0;
      bit_sum_r   <= '0;
      prev_sum_r  <= '0;
      bc_r        <= fsk_pkg::CLOCK_MAX;
      run_r       <= '0;
      await_neg_r <= 1'b0;
      last_sign_r <= 1'b0;
      ptr_r       <= '0;
      wrap_r      <= 1'b0;
      wsum_r      <= '0;
      wabs_r      <= '0;
      rearm_r     <= fsk_pkg::RST_WIN_LEN;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) phase_r <= phase_r + cfg.phase_step;
      if (cmd.commit) begin
        unique case (cmd.op) inside
          [fsk_pkg::OP_LP_FIRST:fsk_pkg::OP_LP_LAST]: begin
            if (rail) lp_q_r[stage] <= lp_val;
            else lp_i_r[stage] <= lp_val;
          end
          fsk_pkg::OP_DISC_B: begin
            prev_i_r <= lp_i_r[3];
            prev_q_r <= lp_q_r[3];
          end
          fsk_pkg::OP_SMOOTH: sd_r <= fsk_pkg::sat24(50'(sd_r) + (prod_r >>> 16));
          default: ;
        endcase
      end
      if (win_clear) begin
        ptr_r   <= '0;
        wrap_r  <= 1'b0;
        wsum_r  <= '0;
        wabs_r  <= '0;
        rearm_r <= win_len_wr;
      end else if (cmd.win) begin
        bit_sum_r <= sum_sat;
        if (cfg.clock_mode == fsk_pkg::MODE_WINDOW) begin
          wsum_r <= wsum_r + WS'(sd_r) - WS'(old_val);
          wabs_r <= wabs_r + WA'(fsk_pkg::abs24(sd_r)) - WA'(fsk_pkg::abs24(old_val));
          if (ptr_inc >= (LW + 1)'(cfg.win_len)) begin
            ptr_r  <= '0;
            wrap_r <= 1'b1;
          end else begin
            ptr_r <= ptr_inc[fsk_pkg::WIN_AW-1:0];
          end
          if (rearm_r != '0) rearm_r <= rearm_r - LW'(1);
        end
      end else if (cmd.adjust) begin
        if (pull_en) bc_r <= pulled;
        if (sum_clr) bit_sum_r <= '0;
        last_sign_r <= last_nxt;
        run_r       <= run_nxt;
        await_neg_r <= await_nxt;
        rearm_r     <= rearm_nxt;
      end else if (cmd.finish) begin
        if (emit) begin
          bc_r       <= '0;
          prev_sum_r <= bit_sum_r;
          bit_sum_r  <= '0;
        end else begin
          bc_r <= bc_inc;
        end
      end
      if (cmd.finish && emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  `ASSERT_CLK(a_ptr_in_range, LW'(ptr_r) < cfg.win_len)
  `ASSERT_NEVER(a_rearm_over_len, rearm_r > cfg.win_len)
  `ASSERT_CLK(a_emit_clears_timer, (cmd.finish && emit) |=> (bc_r == '0) && out_valid_r)

endmodule

// ===== design/fsk_demod_bit_recovery_top.sv =====
// ----------------------------------------------------------------------------
// FSK demodulator with bit clock recovery - top level
// Register block, sequencing controller and datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_sample carries one signed Q1.15 audio
//   sample per item. Output channel out_valid/out_stall/out_data_bit carries a
//   recovered bit each time the bit timer reaches one bit period.
//   After acceptance an item's work runs as a prep step, 13 multiply
//   operations, each an issue and a commit step, through the one shared
//   25x25 multiplier, then ring update, timing adjust and bit decision.
//   in_stall is high while an item is being worked on, so a new sample is
//   taken only once the previous one has finished the whole sequence.
//   A bit, when produced, is valid on the cycle after the item finishes.
//   The finished bit sits in an output register; the next sample is taken
//   while it waits. If that sample also yields a bit and the earlier one is
//   still stalled, the block holds until the receiver takes it.
//   Reset (rst_n low, synchronous) restores register defaults and clears all
//   filter, timer and ring state; the first sample always yields a bit.
//   Configuration writes go through the APB-style port while idle; writing
//   the window length clears the ring at once, no sweep is needed.
// ----------------------------------------------------------------------------
module fsk_demod_bit_recovery_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [15:0]         in_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_data_bit,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [fsk_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  fsk_pkg::cfg_t cfg;
  fsk_pkg::cmd_t cmd;
  fsk_pkg::sts_t sts;
  logic          win_clear;
  logic [fsk_pkg::WIN_LEN_W-1:0] win_len_wr;

  fsk_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg),
    .win_clear   (win_clear),
    .win_len_wr  (win_len_wr)
  );

  fsk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fsk_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .cfg          (cfg),
    .win_clear    (win_clear),
    .win_len_wr   (win_len_wr),
    .in_sample    (in_sample),
    .out_stall    (out_stall),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_data_bit (out_data_bit)
  );

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// FSK demodulator bit recovery testbench
// Drives audio samples over the valid/stall channel and checks every
// recovered bit against a cycle-free model of the mixer, the filters, the
// discriminator and all three bit clock modes. Registers are set over the
// APB-style port between passes. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned TONE_C1 = 64'd1686629713;
  localparam longint unsigned TONE_C2 = 64'd688904916;
  localparam longint unsigned TONE_C3 = 64'd76016958;
  localparam int RING_DEPTH = 256;
  localparam int unsigned TIMER_TOP = 32'hFFFFF;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [15:0] in_sample;
  logic out_valid;
  logic out_stall;
  logic out_data_bit;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [fsk_pkg::CFG_AW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  fsk_demod_bit_recovery_top u_dut (.*);

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // model registers
  bit [31:0] m_phase_step;
  int unsigned m_gain, m_period, m_invert, m_mode, m_threshold, m_win_reg;
  // model state
  bit [31:0] m_nco;
  longint m_lp_i[4], m_lp_q[4];
  longint m_prev_i, m_prev_q, m_smooth, m_sum, m_prev_sum;
  int unsigned m_timer, m_run, m_await_neg, m_last_sign;
  longint m_ring[RING_DEPTH];
  int unsigned m_ptr, m_rearm;
  longint m_wsum, m_wabs;

  logic signed [15:0] pending_samples[$];
  bit expected_bits[$];
  int errors;
  int snd_idle_pct, rcv_idle_pct;
  int hold_req;

  function automatic longint sat_bits(longint v, int w);
    longint hi;
    hi = (longint'(1) << (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint sin_q15(bit [31:0] p);
    bit [31:0] pq;
    longint unsigned r, z, z2, t, q;
    pq = {p[31:22], 22'd0};
    r = pq & 32'h7FFFFFFF;
    if (r > 64'h40000000) r = 64'h80000000 - r;
    z = r;
    z2 = (z * z) >> 30;
    t = TONE_C2 - ((TONE_C3 * z2) >> 30);
    t = TONE_C1 - ((z2 * t) >> 30);
    q = (((z * t) >> 30) + 64'd16384) >> 15;
    if (q > 64'd32767) q = 64'd32767;
    return pq[31] ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint pole(longint s, longint x);
    return sat_bits(s + ((longint'(m_gain) * (x - s)) >>> 16), 24);
  endfunction

  function automatic int unsigned ring_len();
    if (m_win_reg < 1) return 1;
    if (m_win_reg > RING_DEPTH) return RING_DEPTH;
    return m_win_reg;
  endfunction

  function automatic void clear_ring();
    foreach (m_ring[k]) m_ring[k] = 0;
    m_ptr = 0;
    m_wsum = 0;
    m_wabs = 0;
    m_rearm = ring_len();
  endfunction

  function automatic void pull_timer(int unsigned target);
    int unsigned v;
    v = (m_timer + target) >> 1;
    m_timer = v > TIMER_TOP ? TIMER_TOP : v;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic void model_reset();
    m_phase_step = 0;
    m_gain = 6554;
    m_period = 10240;
    m_invert = 0;
    m_mode = 1;
    m_threshold = 4;
    m_win_reg = 8;
    m_nco = 0;
    foreach (m_lp_i[k]) begin
      m_lp_i[k] = 0;
      m_lp_q[k] = 0;
    end
    m_prev_i = 0;
    m_prev_q = 0;
    m_smooth = 0;
    m_sum = 0;
    m_prev_sum = 0;
    m_timer = TIMER_TOP;
    m_run = 0;
    m_await_neg = 0;
    m_last_sign = 0;
    clear_ring();
  endfunction

  function automatic void model_write(fsk_pkg::reg_idx_t idx, bit [31:0] v);
    case (idx)
      fsk_pkg::REG_PHASE_STEP: m_phase_step = v;
      fsk_pkg::REG_FILTER_GAIN: m_gain = v[15:0];
      fsk_pkg::REG_BIT_PERIOD: m_period = v[19:0];
      fsk_pkg::REG_INVERT_SENSE: m_invert = v[0];
      fsk_pkg::REG_CLOCK_MODE: m_mode = v[1:0];
      fsk_pkg::REG_RUN_THRESHOLD: m_threshold = v[8:0];
      fsk_pkg::REG_WINDOW_LENGTH: begin
        m_win_reg = v[8:0];
        clear_ring();
      end
      default: ;
    endcase
  endfunction

  // returns -1 when the sample yields no bit
  function automatic int demod_sample(logic signed [15:0] smp);
    longint s, mi, mq, disc, old;
    int unsigned half, len, ptr;
    bit hit;
    bit b;
    s = smp;
    m_nco = m_nco + m_phase_step;
    mi = sat_bits((s * sin_q15(m_nco + 32'h40000000)) >>> 8, 24);
    mq = sat_bits((s * sin_q15(m_nco)) >>> 8, 24);
    m_lp_i[0] = pole(m_lp_i[0], mi);
    m_lp_q[0] = pole(m_lp_q[0], mq);
    for (int k = 1; k < 4; k++) begin
      m_lp_i[k] = pole(m_lp_i[k], m_lp_i[k-1]);
      m_lp_q[k] = pole(m_lp_q[k], m_lp_q[k-1]);
    end
    disc = m_lp_i[3] * m_prev_q - m_lp_q[3] * m_prev_i;
    disc = sat_bits(disc >>> 22, 24);
    m_prev_i = m_lp_i[3];
    m_prev_q = m_lp_q[3];
    m_smooth = pole(m_smooth, disc);
    m_sum = sat_bits(m_sum + m_smooth, 40);
    half = m_period >> 1;
    if (m_mode == fsk_pkg::MODE_SIGN) begin
      if ((m_smooth >= 0 ? 1 : 0) != m_last_sign) begin
        pull_timer(half);
        m_last_sign = m_smooth >= 0 ? 1 : 0;
        m_sum = 0;
      end
    end else if (m_mode == fsk_pkg::MODE_RUN) begin
      hit = m_await_neg ? (m_smooth < 0) : (m_smooth > 0);
      if (hit) begin
        if (m_run < 1023) m_run++;
        if (m_run > m_threshold) begin
          pull_timer(half + 256 * m_threshold);
          m_run = 0;
          m_sum = 0;
          m_await_neg ^= 1;
        end
      end else begin
        m_run = 0;
      end
    end else if (m_mode == fsk_pkg::MODE_WINDOW) begin
      len = ring_len();
      ptr = m_ptr < len ? m_ptr : 0;
      old = m_ring[ptr];
      m_wsum += m_smooth - old;
      m_wabs += mag(m_smooth) - mag(old);
      m_ring[ptr] = m_smooth;
      ptr++;
      m_ptr = ptr >= len ? 0 : ptr;
      if (m_rearm > 0) m_rearm--;
      if (m_rearm == 0 && m_wabs > 0 && 5 * mag(m_wsum) <= m_wabs) begin
        pull_timer(half + 128 * len);
        m_sum = 0;
        m_rearm = len;
      end
    end
    m_timer = m_timer + 256 > TIMER_TOP ? TIMER_TOP : m_timer + 256;
    if (m_timer < m_period) return -1;
    m_timer = 0;
    b = m_invert ? (m_sum < m_prev_sum) : (m_sum > m_prev_sum);
    m_prev_sum = m_sum;
    m_sum = 0;
    return b;
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst_n && (!in_valid || !in_stall)) begin
      if (pending_samples.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
        in_valid <= 1'b1;
        in_sample <= pending_samples.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // prediction at acceptance
  always @(posedge clk) begin
    int r;
    if (rst_n && in_valid && !in_stall) begin
      r = demod_sample(in_sample);
      if (r >= 0) expected_bits.push_back(r[0]);
    end
  end

  // receiver, with a long hold-off on request
  always @(posedge clk) begin
    int hold_seen;
    int hold_cnt;
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) hold_cnt--;
    out_stall <= (hold_cnt > 0) || ($urandom_range(99) < rcv_idle_pct);
  end

  // checker
  always @(posedge clk) begin
    bit exp_bit;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bits.size() == 0) begin
        $display("%0t: unexpected bit, expected none, actual %0d", $time, out_data_bit);
        errors++;
      end else begin
        exp_bit = expected_bits.pop_front();
        if (out_data_bit !== exp_bit) begin
          $display("%0t: data_bit expected %0d actual %0d", $time, exp_bit, out_data_bit);
          errors++;
        end
      end
    end
  end

  task automatic reg_write(fsk_pkg::reg_idx_t idx, bit [31:0] v);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= fsk_pkg::CFG_AW'(idx) << 2;
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    model_write(idx, v);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic setup(bit [31:0] step, int gain, int period, int inv, int mode,
                       int thr, int win);
    reg_write(fsk_pkg::REG_PHASE_STEP, step);
    reg_write(fsk_pkg::REG_FILTER_GAIN, gain);
    reg_write(fsk_pkg::REG_BIT_PERIOD, period);
    reg_write(fsk_pkg::REG_INVERT_SENSE, inv);
    reg_write(fsk_pkg::REG_CLOCK_MODE, mode);
    reg_write(fsk_pkg::REG_RUN_THRESHOLD, thr);
    reg_write(fsk_pkg::REG_WINDOW_LENGTH, win);
  endtask

  // FSK tone with random bits, amplitude and some noise
  task automatic push_fsk(int n, bit [31:0] centre, bit [31:0] shift, int bit_len);
    bit [31:0] ph;
    int left;
    bit [31:0] step;
    longint amp;
    ph = $urandom;
    left = 0;
    amp = 20000;
    for (int k = 0; k < n; k++) begin
      if (left == 0) begin
        left = bit_len + $urandom_range(2) - 1;
        step = $urandom_range(1) ? centre + shift : centre - shift;
        amp = $urandom_range(32767, 2000);
      end
      left--;
      ph += step;
      if ($urandom_range(99) < 12)
        pending_samples.push_back(16'($urandom));
      else
        pending_samples.push_back(16'((amp * sin_q15(ph)) >>> 15));
    end
  endtask

  task automatic drain();
    wait (pending_samples.size() == 0 && !in_valid && expected_bits.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    out_stall = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    errors = 0;
    hold_req = 0;
    snd_idle_pct = 26;
    rcv_idle_pct = 45;
    model_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: first sample strobes, field extremes
    pending_samples.push_back(16'sh7FFF);
    pending_samples.push_back(-16'sh8000);
    pending_samples.push_back(16'sd0);
    pending_samples.push_back(-16'sd1);
    pending_samples.push_back(16'sd1);
    pending_samples.push_back(16'sh5555);
    pending_samples.push_back(16'shAAAA);
    drain();
    // short period and unused mode, window length zero
    setup(32'hFFFFFFFF, 0, 100, 1, 3, 511, 0);
    pending_samples.push_back(-16'sh8000);
    pending_samples.push_back(16'sh7FFF);
    push_fsk(8, 32'h08000000, 32'h01000000, 3);
    drain();

    // sign change mode
    setup(32'h0C000000, 20000, 256 * 6, 0, fsk_pkg::MODE_SIGN, 4, 8);
    push_fsk(150, 32'h0C000000, 32'h02000000, 6);
    drain();

    // run length mode, long hold-off on the result side
    snd_idle_pct = 45;
    rcv_idle_pct = 26;
    setup(32'h0A000000, 30000, 256 * 5, 1, fsk_pkg::MODE_RUN, 2, 8);
    push_fsk(150, 32'h0A000000, 32'h02800000, 5);
    @(posedge clk);
    hold_req <= hold_req + 1;
    drain();

    // window mode, with neither side idling
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    setup(32'h10000000, 65535, 256 * 8, 0, fsk_pkg::MODE_WINDOW, 0, 16);
    push_fsk(150, 32'h10000000, 32'h03000000, 8);
    drain();

    // clamped window, then run mode with zero threshold, then sign mode with the longest period
    setup(32'h06000000, 45000, 256, 1, fsk_pkg::MODE_WINDOW, 0, 511);
    push_fsk(60, 32'h06000000, 32'h01000000, 2);
    drain();
    setup(32'h06000000, 45000, 256 * 3, 0, fsk_pkg::MODE_RUN, 0, 1);
    push_fsk(60, 32'h06000000, 32'h01800000, 3);
    for (int k = 0; k < 40; k++) pending_samples.push_back(16'($urandom));
    drain();
    setup(32'h0, 6554, 20'hFFFFF, 0, fsk_pkg::MODE_SIGN, 4, 256);
    push_fsk(10, 32'h06000000, 32'h01800000, 3);
    drain();

    if (errors == 0) begin
      $display("fsk_demod_bit_recovery_top: match");
    end else begin
      $display("fsk_demod_bit_recovery_top: mismatch");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("fsk_demod_bit_recovery_top: mismatch");
    $finish;
  end

endmodule
